// File: rtl/core/lpht_pkg.sv
// Shared types and codes of the linear-probing hash table.
// Used by the remainder unit, the sequencer and the top level; no dependencies.
package lpht_pkg;

  localparam int KEY_W = 31;
  localparam int VAL_W = 32;
  localparam int OP_W  = 2;
  localparam int ST_W  = 2;
  localparam int CNT_OUT_W = 5;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
  localparam logic [ST_W-1:0] ST_ABSENT = 2'd2;

  // One request item.
  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [VAL_W-1:0] default_value;
  } lpht_item_t;

  // One result item.
  typedef struct packed {
    logic                 found;
    logic [VAL_W-1:0]     result_value;
    logic [ST_W-1:0]      status;
    logic [CNT_OUT_W-1:0] entry_count;
  } lpht_result_t;

  // One slot of the table memory.
  typedef struct packed {
    logic             used;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } lpht_slot_t;

  // Start request for the remainder unit.
  typedef struct packed {
    logic             start;
    logic [KEY_W-1:0] key;
  } lpht_mod_req_t;

  // Handshake controls from the top level to the sequencer.
  typedef struct packed {
    logic start;
    logic res_take;
  } lpht_cmd_t;

  // Status from the sequencer to the top level.
  typedef struct packed {
    logic idle;
    logic res_valid;
  } lpht_stat_t;

endpackage

// File: rtl/core/lpht_mod_unit.sv
// Remainder unit: key modulo SLOTS by reciprocal multiplication, back-multiply
// and one correcting subtract, one step per cycle. Depends on lpht_pkg.
module lpht_mod_unit
  import lpht_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lpht_mod_req_t              req,
  output logic                       done,
  output logic [$clog2(SLOTS)-1:0]   home
);

  localparam int IW = $clog2(SLOTS);
  localparam int PW = KEY_W + 32;
  // floor(2^32 / SLOTS): the estimated quotient is exact or one too small.
  localparam logic [31:0]      RECIP = 32'((64'd1 << 32) / SLOTS);
  localparam logic [IW:0]      SL    = SLOTS[IW:0];
  localparam logic [KEY_W-1:0] SL_K  = KEY_W'(SLOTS);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_QUOT = 2'd1;
  localparam logic [1:0] PH_REM  = 2'd2;
  localparam logic [1:0] PH_FIX  = 2'd3;

  logic [1:0]       ph_r, ph_nxt;
  logic             done_r, done_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [KEY_W-1:0] quo_r, quo_nxt;
  logic [IW:0]      rem_r, rem_nxt;
  logic [IW-1:0]    home_r, home_nxt;
  logic [PW-1:0]    prod;
  logic [KEY_W-1:0] back;
  logic [KEY_W-1:0] diff;
  logic [IW:0]      fixed;

  // Quotient estimate, back-multiply and the correcting subtract.
  assign prod  = {32'd0, key_r} * {{(PW-32){1'b0}}, RECIP};
  assign back  = quo_r * SL_K;
  assign diff  = key_r - back;
  assign fixed = rem_r - SL;

  always_comb begin
    ph_nxt   = ph_r;
    done_nxt = 1'b0;
    key_nxt  = key_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    home_nxt = home_r;
    if (req.start) begin
      key_nxt = req.key;
      ph_nxt  = PH_QUOT;
    end else begin
      unique case (ph_r)
        PH_IDLE: ph_nxt = PH_IDLE;
        PH_QUOT: begin
          quo_nxt = prod[PW-1:32];
          ph_nxt  = PH_REM;
        end
        PH_REM: begin
          // The true remainder is below twice SLOTS, so the low bits suffice.
          rem_nxt = diff[IW:0];
          ph_nxt  = PH_FIX;
        end
        PH_FIX: begin
          home_nxt = (rem_r >= SL) ? fixed[IW-1:0] : rem_r[IW-1:0];
          done_nxt = 1'b1;
          ph_nxt   = PH_IDLE;
        end
        default: ph_nxt = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= done_nxt;
    end
    key_r  <= key_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    home_r <= home_nxt;
  end

  assign done = done_r;
  assign home = home_r;

endmodule

// File: rtl/core/lpht_ctrl.sv
// Probe sequencer with the slot memory, the entry count and the result registers.
// Depends on lpht_pkg and lpht_mod_unit.
module lpht_ctrl
  import lpht_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  lpht_cmd_t    cmd,
  input  lpht_item_t   item,
  output lpht_stat_t   stat,
  output lpht_result_t result
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [IW-1:0] TOP_IDX = IW'(SLOTS - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(SLOTS);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_HASH  = 4'd2;
  localparam logic [3:0] S_FRD   = 4'd3;
  localparam logic [3:0] S_FEV   = 4'd4;
  localparam logic [3:0] S_SRD   = 4'd5;
  localparam logic [3:0] S_SEV   = 4'd6;
  localparam logic [3:0] S_RHASH = 4'd7;
  localparam logic [3:0] S_PRD   = 4'd8;
  localparam logic [3:0] S_PEV   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0]       state_r, state_nxt;
  logic [IW-1:0]    clr_r, clr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [OP_W-1:0]  op_r, op_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [VAL_W-1:0] dflt_r, dflt_nxt;
  logic [IW-1:0]    addr_r, addr_nxt;
  logic [IW-1:0]    n_r, n_nxt;
  logic [IW-1:0]    sj_r, sj_nxt;
  logic [IW-1:0]    sn_r, sn_nxt;
  logic [KEY_W-1:0] mk_r, mk_nxt;
  logic [VAL_W-1:0] mv_r, mv_nxt;
  logic             res_found_r, res_found_nxt;
  logic [VAL_W-1:0] res_value_r, res_value_nxt;
  logic [ST_W-1:0]  res_status_r, res_status_nxt;

  logic             mem_we, mem_re;
  logic [IW-1:0]    mem_addr;
  lpht_slot_t       mem_wdata;
  lpht_slot_t       rd_r;
  lpht_slot_t       mem [SLOTS];

  lpht_mod_req_t    mod_req;
  logic             mod_done;
  logic [IW-1:0]    mod_home;
  logic [IW-1:0]    addr_inc, sj_inc;
  logic [CW+CNT_OUT_W-1:0] count_ext;

  lpht_mod_unit #(.SLOTS(SLOTS)) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .done  (mod_done),
    .home  (mod_home)
  );

  // Next slot along the probe run, wrapping at the end of the table.
  assign addr_inc = (addr_r == TOP_IDX) ? '0 : addr_r + IW'(1);
  assign sj_inc   = (sj_r == TOP_IDX) ? '0 : sj_r + IW'(1);

  // Slot memory: one access per cycle, registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_r <= mem[mem_addr];
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    count_nxt      = count_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    dflt_nxt       = dflt_r;
    addr_nxt       = addr_r;
    n_nxt          = n_r;
    sj_nxt         = sj_r;
    sn_nxt         = sn_r;
    mk_nxt         = mk_r;
    mv_nxt         = mv_r;
    res_found_nxt  = res_found_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_addr       = addr_r;
    mem_wdata      = '{used: 1'b1, key: key_r, value: val_r};
    mod_req        = '{start: 1'b0, key: item.key};

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_r;
        mem_wdata = '{used: 1'b0, key: '0, value: '0};
        clr_nxt   = clr_r + IW'(1);
        if (clr_r == TOP_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd.start) begin
          op_nxt         = item.opcode;
          key_nxt        = item.key;
          val_nxt        = item.value;
          dflt_nxt       = item.default_value;
          res_found_nxt  = 1'b0;
          res_value_nxt  = '0;
          res_status_nxt = ST_DONE;
          if (item.opcode == OP_INSERT || item.opcode == OP_DELETE ||
              item.opcode == OP_LOOKUP) begin
            mod_req.start = 1'b1;
            state_nxt     = S_HASH;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_HASH: begin
        if (mod_done) begin
          addr_nxt  = mod_home;
          n_nxt     = '0;
          state_nxt = S_FRD;
        end
      end
      S_FRD: begin
        mem_re    = 1'b1;
        mem_addr  = addr_r;
        state_nxt = S_FEV;
      end
      S_FEV: begin
        if (!rd_r.used) begin
          // Empty slot ends the run: the key is absent.
          state_nxt = S_DONE;
          case (op_r)
            OP_INSERT: begin
              mem_we    = 1'b1;
              count_nxt = count_r + CW'(1);
            end
            OP_DELETE: res_status_nxt = ST_ABSENT;
            default:   res_value_nxt  = dflt_r;
          endcase
        end else if (rd_r.key == key_r) begin
          res_found_nxt = 1'b1;
          state_nxt     = S_DONE;
          case (op_r)
            OP_INSERT: mem_we = 1'b1;
            OP_DELETE: begin
              // Free the slot, then walk the rest of the cluster.
              mem_we    = 1'b1;
              mem_wdata = '{used: 1'b0, key: rd_r.key, value: rd_r.value};
              count_nxt = count_r - CW'(1);
              sj_nxt    = addr_inc;
              sn_nxt    = IW'(1);
              state_nxt = S_SRD;
            end
            default: res_value_nxt = rd_r.value;
          endcase
        end else if (n_r == TOP_IDX) begin
          // Whole table probed without a match or an empty slot.
          state_nxt = S_DONE;
          case (op_r)
            OP_INSERT: res_status_nxt = ST_FULL;
            OP_DELETE: res_status_nxt = ST_ABSENT;
            default:   res_value_nxt  = dflt_r;
          endcase
        end else begin
          addr_nxt  = addr_inc;
          n_nxt     = n_r + IW'(1);
          state_nxt = S_FRD;
        end
      end
      S_SRD: begin
        mem_re    = 1'b1;
        mem_addr  = sj_r;
        state_nxt = S_SEV;
      end
      S_SEV: begin
        if (!rd_r.used) begin
          state_nxt = S_DONE;
        end else begin
          // Lift the entry out and hash its key again.
          mk_nxt        = rd_r.key;
          mv_nxt        = rd_r.value;
          mem_we        = 1'b1;
          mem_addr      = sj_r;
          mem_wdata     = '{used: 1'b0, key: rd_r.key, value: rd_r.value};
          mod_req.start = 1'b1;
          mod_req.key   = rd_r.key;
          state_nxt     = S_RHASH;
        end
      end
      S_RHASH: begin
        if (mod_done) begin
          addr_nxt  = mod_home;
          state_nxt = S_PRD;
        end
      end
      S_PRD: begin
        mem_re    = 1'b1;
        mem_addr  = addr_r;
        state_nxt = S_PEV;
      end
      S_PEV: begin
        if (!rd_r.used) begin
          // First empty slot of its own run; the freed slot guarantees one.
          mem_we    = 1'b1;
          mem_wdata = '{used: 1'b1, key: mk_r, value: mv_r};
          if (sn_r == TOP_IDX) begin
            state_nxt = S_DONE;
          end else begin
            sj_nxt    = sj_inc;
            sn_nxt    = sn_r + IW'(1);
            state_nxt = S_SRD;
          end
        end else begin
          addr_nxt  = addr_inc;
          state_nxt = S_PRD;
        end
      end
      S_DONE: begin
        if (cmd.res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      count_r <= count_nxt;
    end
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    dflt_r       <= dflt_nxt;
    addr_r       <= addr_nxt;
    n_r          <= n_nxt;
    sj_r         <= sj_nxt;
    sn_r         <= sn_nxt;
    mk_r         <= mk_nxt;
    mv_r         <= mv_nxt;
    res_found_r  <= res_found_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
  end

  // Result and status toward the top level.
  assign count_ext = {{CNT_OUT_W{1'b0}}, count_r};
  assign stat.idle      = (state_r == S_IDLE);
  assign stat.res_valid = (state_r == S_DONE);
  assign result.found        = res_found_r;
  assign result.result_value = res_value_r;
  assign result.status       = res_status_r;
  assign result.entry_count  = count_ext[CNT_OUT_W-1:0];

  // The single memory port is never asked to read and write at once.
  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("slot memory read and written in the same cycle");

  // A full refusal only happens when every slot is occupied.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && res_status_r == ST_FULL) |-> (count_r == FULL_CNT))
    else $error("full status with free slots");

  // The entry count never exceeds the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count above table size");

  // The remainder unit only finishes while the sequencer waits for it.
  a_hash_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> (state_r == S_HASH || state_r == S_RHASH))
    else $error("hash result arrived outside a wait state");

  // An absent or full result never reports a found key.
  a_status_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && res_status_r != ST_DONE) |-> !res_found_r)
    else $error("error status with found set");

endmodule

// File: rtl/core/linear_probe_hash_table_top.sv
// Top level of the linear-probing hash table: stream ports and output register.
// Depends on lpht_pkg and lpht_ctrl.
//
// Open-addressed hash table of SLOTS slots with linear probing; the home slot is
// key modulo SLOTS. After reset the block clears the slot memory and accepts no
// item meanwhile. It then works on one item at a time: the home slot comes from
// a remainder unit (reciprocal multiply, back-multiply and one correction), and
// each probed slot is read and then evaluated on the single-port slot memory.
// A delete that hits also walks the rest of the cluster: each later slot is
// read, and every entry there is lifted out, hashed again and placed in the
// first empty slot probed from its home. An unused opcode skips the table and
// goes straight to the result. The result item sits in an output register, so
// the next item is accepted while it waits.
module linear_probe_hash_table_top
  import lpht_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // Bits from low: key[30:0], value[62:31], default_value[94:63], zero pad.
  input  logic [95:0] in_tdata,
  // Bits from low: opcode[1:0].
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // Bits from low: result_value[31:0], entry_count[36:32], zero pad.
  output logic [39:0] out_tdata,
  // Bits from low: found[0], status[2:1].
  output logic [2:0]  out_tuser
);

  lpht_cmd_t    cmd;
  lpht_stat_t   stat;
  lpht_item_t   item;
  lpht_result_t result;

  logic         out_valid_r, out_valid_nxt;
  lpht_result_t out_r;
  logic         take;

  // Unpack the request item.
  assign item.opcode        = in_tuser;
  assign item.key           = in_tdata[KEY_W-1:0];
  assign item.value         = in_tdata[KEY_W+VAL_W-1:KEY_W];
  assign item.default_value = in_tdata[KEY_W+2*VAL_W-1:KEY_W+VAL_W];

  assign in_tready    = stat.idle;
  assign take         = stat.res_valid && (!out_valid_r || out_tready);
  assign cmd.start    = in_tvalid && stat.idle;
  assign cmd.res_take = take;

  lpht_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .item   (item),
    .stat   (stat),
    .result (result)
  );

  // Output register: loads a finished result when empty or being drained.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (take) begin
      out_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_r.entry_count, out_r.result_value};
  assign out_tuser  = {out_r.status, out_r.found};

endmodule
